>>> rtl/core/sssd_pkg.sv
// shared constants, types and segment table for the serial display driver
`default_nettype none

package sssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int BIN_W       = 16;
    localparam int BCD_W       = 4 * DIGIT_COUNT;
    localparam int FRAME_BITS  = 8 * DIGIT_COUNT;
    localparam int IDX_W       = $clog2(FRAME_BITS);
    localparam int CNT_W       = $clog2(BIN_W);

    localparam logic [7:0] SEG_F  = 8'b0000_0001;
    localparam logic [7:0] SEG_DP = 8'b0000_0010;
    localparam logic [7:0] SEG_E  = 8'b0000_0100;
    localparam logic [7:0] SEG_C  = 8'b0000_1000;
    localparam logic [7:0] SEG_D  = 8'b0001_0000;
    localparam logic [7:0] SEG_B  = 8'b0010_0000;
    localparam logic [7:0] SEG_A  = 8'b0100_0000;
    localparam logic [7:0] SEG_G  = 8'b1000_0000;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } t_conv_state;

    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } t_bcd_req;

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] seg;
        seg = 8'h00;
        case (digit)
            4'd0: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1: seg = SEG_B | SEG_C;
            4'd2: seg = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4: seg = SEG_B | SEG_C | SEG_F | SEG_G;
            4'd5: seg = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
            4'd6: seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd7: seg = SEG_A | SEG_B | SEG_C;
            4'd8: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sssd_bcd_conv.sv
// bit-serial binary to bcd converter, shift and add three, one input bit per cycle
`default_nettype none

module sssd_bcd_conv (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [sssd_pkg::BIN_W-1:0]   i_display_value,
    output sssd_pkg::t_bcd_req                o_req,
    input  wire logic                         i_take
);
    import sssd_pkg::*;

    t_conv_state      r_state, n_state;
    logic [BIN_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [CNT_W-1:0] r_cnt;
    logic [BCD_W-1:0] w_adj;
    logic             w_accept;

    assign w_accept = i_valid && !o_stall;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CONV_IDLE: begin
                if (i_valid) begin
                    n_state = CONV_RUN;
                end
            end
            CONV_RUN: begin
                if (r_cnt == CNT_W'(BIN_W - 1)) begin
                    n_state = CONV_DONE;
                end
            end
            CONV_DONE: begin
                if (i_take) begin
                    n_state = CONV_IDLE;
                end
            end
            default: n_state = CONV_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = (r_state != CONV_IDLE);
        o_req.valid = (r_state == CONV_DONE);
        o_req.bcd   = r_bcd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CONV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == CONV_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // carry out of the top digit drops, which keeps the value modulo ten thousand
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bin <= i_display_value;
            r_bcd <= '0;
        end else if (r_state == CONV_RUN) begin
            r_bin <= {r_bin[BIN_W-2:0], 1'b0};
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[BIN_W-1]};
        end
    end

    a_conv_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##(BIN_W + 1) o_req.valid)
        else $error("conversion did not finish in time");

    a_take_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_req.valid) |=> !o_req.valid && !o_stall)
        else $error("converter did not release after handoff");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CONV_RUN) |-> o_stall && !o_req.valid)
        else $error("converter open during conversion");

endmodule

`default_nettype wire

>>> rtl/core/sssd_shifter.sv
// segment encoder and serial frame shifter, one bit per cycle while the output is not stalled
`default_nettype none

module sssd_shifter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_msb_first,
    input  wire sssd_pkg::t_bcd_req i_req,
    output logic                    o_take,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_serial_bit,
    output logic [1:0]              o_digit_position,
    output logic                    o_last
);
    import sssd_pkg::*;

    logic                  r_active;
    logic [IDX_W-1:0]      r_idx;
    logic [FRAME_BITS-1:0] r_shift;
    logic [FRAME_BITS-1:0] w_frame;
    logic [IDX_W-1:0]      w_dig;
    logic                  w_step;

    assign o_take = i_req.valid && !r_active;
    assign w_step = r_active && !i_stall;

    // active-low bytes, bit order fixed at load
    always_comb begin
        logic [7:0] inv;
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            inv = ~glyph(i_req.bcd[d*4 +: 4]);
            for (int j = 0; j < 8; j++) begin
                w_frame[d*8 + j] = i_msb_first ? inv[7-j] : inv[j];
            end
        end
    end

    assign w_dig            = r_idx >> 3;
    assign o_valid          = r_active;
    assign o_serial_bit     = r_shift[0];
    assign o_digit_position = w_dig[1:0];
    assign o_last           = r_active && (r_idx == IDX_W'(FRAME_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (o_take) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (w_step) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == IDX_W'(FRAME_BITS - 1)) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_shift <= w_frame;
        end else if (w_step) begin
            r_shift <= r_shift >> 1;
        end
    end

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && !i_stall) |=> !o_valid)
        else $error("shifter kept running past the last bit");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> o_valid && (o_digit_position == 2'd0) && !o_last)
        else $error("frame did not start at the ones digit");

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_digit_position == 2'(DIGIT_COUNT - 1)))
        else $error("last bit outside the top digit");

endmodule

`default_nettype wire

>>> rtl/core/seven_segment_serial_display_driver.sv
// top level: four-digit seven-segment serial display driver
// the first serial bit follows the bit-serial bcd conversion of an accepted request
// and the load of the frame shifter, which waits while the shifter is still busy
// requests are paced by the 32-bit frame shifter and by output stalls;
// the next request is converted while the current frame shifts out
// reset: synchronous active low, clears control state and msb_first to 0
`default_nettype none

module seven_segment_serial_display_driver (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [sssd_pkg::BIN_W-1:0]   i_display_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_serial_bit,
    output logic [1:0]                        o_digit_position,
    output logic                              o_last
);
    import sssd_pkg::*;

    logic     r_msb_first;
    t_bcd_req w_req;
    logic     w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_first <= 1'b0;
        end else if (i_cfg_we) begin
            r_msb_first <= i_cfg_wdata;
        end
    end

    sssd_bcd_conv u_conv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_display_value (i_display_value),
        .o_req           (w_req),
        .i_take          (w_take)
    );

    sssd_shifter u_shift (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_msb_first      (r_msb_first),
        .i_req            (w_req),
        .o_take           (w_take),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_serial_bit     (o_serial_bit),
        .o_digit_position (o_digit_position),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

>>> test/seven_segment_serial_display_driver_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the seven-segment serial display driver
module seven_segment_serial_display_driver_tb;
    import sssd_pkg::*;

    typedef struct packed {
        logic       serial;
        logic [1:0] position;
        logic       last;
    } t_frame_bit;

    typedef struct packed {
        logic [15:0] value;
        logic        msb;
        logic        typed;
        logic [31:0] frame;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 22;
    localparam int PHASE_ITEMS   = 103;
    localparam int SETTLE_CYCLES = 40;

    // which decimal digits light each segment, bit i for digit i
    localparam logic [9:0] LIT_A = 10'h3ED;
    localparam logic [9:0] LIT_B = 10'h39F;
    localparam logic [9:0] LIT_C = 10'h3FB;
    localparam logic [9:0] LIT_D = 10'h36D;
    localparam logic [9:0] LIT_E = 10'h145;
    localparam logic [9:0] LIT_F = 10'h371;
    localparam logic [9:0] LIT_G = 10'h37C;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_display_value = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_serial_bit;
    logic [1:0]  o_digit_position;
    logic        o_last;

    t_frame_bit pending_bits[$];
    logic       order_msb = 1'b0;
    bit         idle_on = 1'b0;
    int         mismatch_count = 0;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{16'd0,     1'b0, 1'b1, 32'h8282_8282},
        '{16'd65535, 1'b0, 1'b1, 32'h2626_0726},
        '{16'd8888,  1'b0, 1'b1, 32'h0202_0202},
        '{16'd1111,  1'b0, 1'b1, 32'hD7D7_D7D7},
        '{16'd10000, 1'b0, 1'b1, 32'h8282_8282},
        '{16'd9999,  1'b0, 1'b0, 32'h0},
        '{16'd1234,  1'b0, 1'b0, 32'h0},
        '{16'd5678,  1'b0, 1'b0, 32'h0},
        '{16'd9012,  1'b0, 1'b0, 32'h0},
        '{16'd12345, 1'b0, 1'b0, 32'h0},
        '{16'd20000, 1'b0, 1'b0, 32'h0},
        '{16'd54321, 1'b0, 1'b0, 32'h0},
        '{16'd65530, 1'b0, 1'b0, 32'h0},
        '{16'd1,     1'b0, 1'b0, 32'h0},
        '{16'd0,     1'b1, 1'b1, 32'h8282_8282},
        '{16'd65535, 1'b1, 1'b1, 32'h2626_0726},
        '{16'd8888,  1'b1, 1'b1, 32'h0202_0202},
        '{16'd3456,  1'b1, 1'b0, 32'h0},
        '{16'd7890,  1'b1, 1'b0, 32'h0},
        '{16'd19999, 1'b1, 1'b0, 32'h0},
        '{16'd10009, 1'b1, 1'b0, 32'h0},
        '{16'd100,   1'b1, 1'b0, 32'h0}
    };

    seven_segment_serial_display_driver u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_display_value  (i_display_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_serial_bit     (o_serial_bit),
        .o_digit_position (o_digit_position),
        .o_last           (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] digit_segments(input int digit);
        return (LIT_A[digit] ? SEG_A : 8'h00) | (LIT_B[digit] ? SEG_B : 8'h00)
             | (LIT_C[digit] ? SEG_C : 8'h00) | (LIT_D[digit] ? SEG_D : 8'h00)
             | (LIT_E[digit] ? SEG_E : 8'h00) | (LIT_F[digit] ? SEG_F : 8'h00)
             | (LIT_G[digit] ? SEG_G : 8'h00);
    endfunction

    // inverted segment bytes, ones digit in the low byte
    function automatic logic [31:0] segment_frame(input logic [15:0] value);
        logic [31:0] frame;
        int rest;
        rest = value;
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            frame[8*d +: 8] = ~digit_segments(rest % 10);
            rest = rest / 10;
        end
        return frame;
    endfunction

    function automatic void queue_frame(input logic [31:0] frame);
        t_frame_bit entry;
        for (int d = 0; d < DIGIT_COUNT; d++) begin
            for (int b = 0; b < 8; b++) begin
                entry.serial   = frame[8*d + (order_msb ? 7 - b : b)];
                entry.position = d[1:0];
                entry.last     = (d == DIGIT_COUNT - 1) && (b == 7);
                pending_bits.push_back(entry);
            end
        end
    endfunction

    function automatic logic [15:0] random_value();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 9999));
            1: return 16'($urandom_range(9990, 10010));
            2: return 16'($urandom_range(65000, 65535));
            3: return 16'(10000 * $urandom_range(0, 6) + $urandom_range(0, 9));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s", what);
        end
    endfunction

    task automatic send_value(input logic [15:0] value, input logic typed,
                              input logic [31:0] frame);
        i_in_valid <= 1'b1;
        i_display_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        queue_frame(typed ? frame : segment_frame(value));
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic await_idle();
        i_in_valid <= 1'b0;
        while (pending_bits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_msb_first(input logic value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        order_msb = value;
    endtask

    always begin : out_stall_bursts
        @(posedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            i_out_stall <= 1'b0;
            repeat ($urandom_range(0, 40)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_bits
        t_frame_bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bits.size() == 0) begin
                note_mismatch($sformatf("unexpected bit: serial %0b position %0d last %0b",
                                        o_serial_bit, o_digit_position, o_last));
            end else begin
                want = pending_bits.pop_front();
                if (o_serial_bit !== want.serial) begin
                    note_mismatch($sformatf("serial_bit expected %0b got %0b",
                                            want.serial, o_serial_bit));
                end
                if (o_digit_position !== want.position) begin
                    note_mismatch($sformatf("digit_position expected %0d got %0d",
                                            want.position, o_digit_position));
                end
                if (o_last !== want.last) begin
                    note_mismatch($sformatf("last expected %0b got %0b", want.last, o_last));
                end
            end
        end
    end

    initial begin
        t_stim_row row;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_msb_first(1'b0);
        idle_on = 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_rows[i];
            if (row.msb != order_msb) begin
                await_idle();
                write_msb_first(row.msb);
            end
            send_value(row.value, row.typed, row.frame);
        end
        for (int p = 0; p < 4; p++) begin
            await_idle();
            write_msb_first(~order_msb);
            idle_on = (p != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_value(random_value(), 1'b0, 32'h0);
            end
        end
        await_idle();
        if (mismatch_count == 0 && pending_bits.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
